[hdl/catan_pkg.sv]
package catan_pkg;

    localparam int ITERATIONS_DEFAULT = 10;
    localparam int DATA_WIDTH_DEFAULT = 16;
    localparam int GUARD_BITS         = 2;
    localparam int GROWTH_BITS        = 4;
    localparam int ANGLE_WIDTH        = 15;
    localparam int ROM_INDEX_WIDTH    = 4;

    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

    // atan(2^-i) in q2.13, rounded to nearest
    function automatic angle_t atan_entry(input logic [ROM_INDEX_WIDTH-1:0] idx);
        angle_t val;
        case (idx)
            4'd0:    val = 15'sd6434;
            4'd1:    val = 15'sd3798;
            4'd2:    val = 15'sd2007;
            4'd3:    val = 15'sd1019;
            4'd4:    val = 15'sd511;
            4'd5:    val = 15'sd256;
            4'd6:    val = 15'sd128;
            4'd7:    val = 15'sd64;
            4'd8:    val = 15'sd32;
            4'd9:    val = 15'sd16;
            4'd10:   val = 15'sd8;
            4'd11:   val = 15'sd4;
            4'd12:   val = 15'sd2;
            4'd13:   val = 15'sd1;
            default: val = 15'sd0;
        endcase
        return val;
    endfunction

endpackage

[hdl/cordic_arctangent.sv]
// datapath: a chain of registered micro-rotation cells from request to result
// throughput: one request per cycle while m_tready is high, each cell hands its x, y and angle to the next
// every cell refills as soon as its result moves on, so bubbles close up under stalls
// reset: synchronous active-low aresetn clears the valid flag of every cell
module cordic_arctangent
    import catan_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // y_coord, x_coord
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // angle
    output logic [((ANGLE_WIDTH+7)/8)*8-1:0]    m_tdata
);

    localparam int WORK_WIDTH = DATA_WIDTH + GUARD_BITS + GROWTH_BITS;
    localparam int OUT_WIDTH  = ((ANGLE_WIDTH + 7) / 8) * 8;

    logic                         valid_chain [0:ITERATIONS];
    logic                         ready_chain [0:ITERATIONS];
    logic signed [WORK_WIDTH-1:0] x_chain     [0:ITERATIONS];
    logic signed [WORK_WIDTH-1:0] y_chain     [0:ITERATIONS];
    angle_t                       angle_chain [0:ITERATIONS];

    logic signed [DATA_WIDTH-1:0] y_coord;
    logic signed [DATA_WIDTH-1:0] x_coord;

    assign y_coord = s_tdata[DATA_WIDTH-1:0];
    assign x_coord = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    // sign extend and add guard bits
    assign x_chain[0]     = WORK_WIDTH'(x_coord) <<< GUARD_BITS;
    assign y_chain[0]     = WORK_WIDTH'(y_coord) <<< GUARD_BITS;
    assign angle_chain[0] = '0;
    assign valid_chain[0] = s_tvalid;
    assign s_tready       = ready_chain[0];

    genvar i;
    generate
        for (i = 0; i < ITERATIONS; i++) begin : g_cell
            catan_cell #(
                .STAGE      (i),
                .WORK_WIDTH (WORK_WIDTH)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (valid_chain[i]),
                .in_ready  (ready_chain[i]),
                .in_x      (x_chain[i]),
                .in_y      (y_chain[i]),
                .in_angle  (angle_chain[i]),
                .out_valid (valid_chain[i+1]),
                .out_ready (ready_chain[i+1]),
                .out_x     (x_chain[i+1]),
                .out_y     (y_chain[i+1]),
                .out_angle (angle_chain[i+1])
            );
        end
    endgenerate

    assign ready_chain[ITERATIONS] = m_tready;
    assign m_tvalid = valid_chain[ITERATIONS];
    assign m_tdata  = OUT_WIDTH'({1'b0, angle_chain[ITERATIONS]});

endmodule

[hdl/catan_cell.sv]
module catan_cell
    import catan_pkg::*;
#(
    parameter int STAGE      = 0,
    parameter int WORK_WIDTH = DATA_WIDTH_DEFAULT + GUARD_BITS + GROWTH_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [WORK_WIDTH-1:0] in_x,
    input  logic signed [WORK_WIDTH-1:0] in_y,
    input  angle_t                       in_angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [WORK_WIDTH-1:0] out_x,
    output logic signed [WORK_WIDTH-1:0] out_y,
    output angle_t                       out_angle
);

    logic                         valid_reg;
    logic signed [WORK_WIDTH-1:0] x_reg, x_next;
    logic signed [WORK_WIDTH-1:0] y_reg, y_next;
    angle_t                       angle_reg, angle_next;
    logic signed [WORK_WIDTH-1:0] dx, dy;
    angle_t                       step_angle;

    assign in_ready   = !valid_reg || out_ready;
    assign step_angle = atan_entry(ROM_INDEX_WIDTH'(STAGE));
    assign dx         = in_y >>> STAGE;
    assign dy         = in_x >>> STAGE;

    always_comb begin
        if (in_y > 0) begin
            x_next     = in_x + dx;
            y_next     = in_y - dy;
            angle_next = in_angle + step_angle;
        end else begin
            x_next     = in_x - dx;
            y_next     = in_y + dy;
            angle_next = in_angle - step_angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_angle = angle_reg;

endmodule

[tb/arctan_checker.sv]
module arctan_checker
    import catan_pkg::*;
(
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    input  logic                                        s_tready,
    // y_coord, x_coord
    input  logic [((2*DATA_WIDTH_DEFAULT+7)/8)*8-1:0]   s_tdata,
    input  logic                                        m_tvalid,
    input  logic                                        m_tready,
    // angle
    input  logic [((ANGLE_WIDTH+7)/8)*8-1:0]            m_tdata,
    output int                                          pending,
    output int                                          mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = DATA_WIDTH_DEFAULT;
    localparam int MAX_PRINTS = 200;

    typedef logic signed [DW-1:0] coord_t;

    typedef struct {
        coord_t y;
        coord_t x;
        angle_t angle;
    } angle_entry_t;

    // atan(2^-i) in q2.13
    int atan_step [16] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                           32, 16, 8, 4, 2, 1, 0, 0};

    angle_entry_t angle_queue [$];

    function automatic angle_t cordic_angle(input coord_t y_in, input coord_t x_in);
        int y_w;
        int x_w;
        int dx;
        int dy;
        int acc;
        int step;
        int acc_bits;
        y_w = int'(y_in) * (1 << GUARD_BITS);
        x_w = int'(x_in) * (1 << GUARD_BITS);
        acc = 0;
        for (int i = 0; i < ITERATIONS_DEFAULT; i++) begin
            step = (i < 16) ? atan_step[i] : 0;
            dx = y_w >>> i;
            dy = x_w >>> i;
            // zero y rotates the negative way
            if (y_w > 0) begin
                x_w = x_w + dx;
                y_w = y_w - dy;
                acc = acc + step;
            end else begin
                x_w = x_w - dx;
                y_w = y_w + dy;
                acc = acc - step;
            end
        end
        acc_bits = acc;
        return angle_t'(acc_bits[ANGLE_WIDTH-1:0]);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : monitor
        angle_entry_t entry;
        angle_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                entry.y = s_tdata[DW-1:0];
                entry.x = s_tdata[2*DW-1:DW];
                entry.angle = cordic_angle(entry.y, entry.x);
                angle_queue.push_back(entry);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[ANGLE_WIDTH-1:0];
                if (angle_queue.size() == 0) begin
                    report_mismatch($sformatf("result angle %0d with no request waiting", got));
                end else begin
                    entry = angle_queue.pop_front();
                    if (got !== entry.angle)
                        report_mismatch($sformatf("y %0d x %0d: angle %0d, want %0d",
                                                  entry.y, entry.x, got, entry.angle));
                end
            end
        end
        pending <= angle_queue.size();
    end

endmodule

[tb/cordic_arctangent_tb.sv]
module cordic_arctangent_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import catan_pkg::*;

    localparam int DW = DATA_WIDTH_DEFAULT;
    localparam int S_WIDTH = ((2*DW+7)/8)*8;
    localparam int M_WIDTH = ((ANGLE_WIDTH+7)/8)*8;
    localparam int PHASE_ITEMS = 345;

    typedef logic signed [DW-1:0] coord_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // y_coord, x_coord
    logic [S_WIDTH-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // angle
    logic [M_WIDTH-1:0] m_tdata;

    int pending;
    int mismatch_count;
    int send_idle_pct = 0;
    int ready_stall_pct = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    cordic_arctangent i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    arctan_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .pending        (pending),
        .mismatch_count (mismatch_count)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    task automatic send_pair(input coord_t y, input coord_t x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_WIDTH'({x, y});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        coord_t y;
        coord_t x;
        coord_t corners [5];
        corners = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
        send_idle_pct = idle_pct;
        ready_stall_pct <= stall_pct;
        repeat (count) begin
            y = coord_t'($urandom);
            x = coord_t'($urandom);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: x[DW-1] = 1'b0;
                6: y = '0;
                7: begin
                    y = coord_t'($urandom_range(32)) - 16'sd16;
                    x = coord_t'($urandom_range(32)) - 16'sd16;
                end
                8: begin
                    y = corners[$urandom_range(4)];
                    x = corners[$urandom_range(4)];
                end
                default: ;
            endcase
            send_pair(y, x);
        end
        // hold off until every result is back
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes, zero y, negative x
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd0, 16'sd32767);
        send_pair(16'sd32767, 16'sd32767);
        send_pair(-16'sd32768, 16'sd32767);
        send_pair(16'sd32767, 16'sd0);
        send_pair(-16'sd32768, 16'sd0);
        send_pair(16'sd0, -16'sd32768);
        send_pair(16'sd32767, -16'sd32768);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(-16'sd1, -16'sd1);
        send_pair(16'sd1, 16'sd1);
        send_pair(16'sd1, 16'sd0);
        send_pair(16'sd0, 16'sd1);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sd32767, 16'sd1);
        send_pair(-16'sd32768, 16'sd1);
        send_pair(16'sd100, 16'sd200);
        send_pair(-16'sd200, 16'sd50);
        send_pair(16'sd5, -16'sd7);
        send_pair(16'sd0, -16'sd1);
        send_pair(-16'sd21846, 16'sd21845);
        wait_drained();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(62, 0, PHASE_ITEMS);
        run_phase(0, 62, PHASE_ITEMS);
        run_phase(23, 23, PHASE_ITEMS);

        repeat (4 * ITERATIONS_DEFAULT) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
